/* sv/ael_pkg.sv */
package ael_pkg;

    localparam int VALUE_BITS    = 32;
    localparam int POSITION_BITS = 16;
    localparam int LENGTH_BITS   = 8;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [2:0] {
        KIND_PLUS  = 3'd0,
        KIND_MINUS = 3'd1,
        KIND_STAR  = 3'd2,
        KIND_SLASH = 3'd3,
        KIND_INT   = 3'd4,
        KIND_BAD   = 3'd5
    } t_kind;

    typedef struct packed {
        t_kind                    kind;
        logic [VALUE_BITS-1:0]    value;
        logic [LENGTH_BITS-1:0]   length;
        logic [POSITION_BITS-1:0] line;
        logic [POSITION_BITS-1:0] column;
        logic                     overflow;
        logic                     last;
    } t_token;

endpackage

/* sv/arith_expression_lexer_top.sv */
// Byte-stream lexer for integer arithmetic expressions.
//
// Input channel (i_in_valid / o_in_ready): one source byte per item, with
// i_final_byte set on the last byte of a source. Output channel
// (o_out_valid / i_out_ready): one token per item, kind, value, digit count,
// line and column of its first byte, overflow flag, and o_last_of_run on the
// last token that a given byte produced.
//
// Each accepted byte is decoded in the cycle it is taken; its tokens are
// registered into a three-slot output queue. One byte per cycle is sustained
// while the queue has room; a byte that ends a number and is itself an
// operator or invalid yields two tokens, which drain one per cycle from the
// queue while the receiver is ready. The queue takes a byte whenever at
// least two slots are free after this cycle's pop, so a waiting token does
// not block input. Receiver stall: tokens hold in the queue; input stops
// once the queue can no longer absorb a worst-case two-token byte.
//
// Reset (synchronous, active low): queue empty, position back to line 1,
// no number pending. The final byte of a source returns the lexer to the
// same state, so the next byte starts a new source at line 1, column 1.
module arith_expression_lexer_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [7:0]                        i_source_byte,
    input  logic                              i_final_byte,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [2:0]                        o_token_kind,
    output logic [ael_pkg::VALUE_BITS-1:0]    o_token_value,
    output logic [ael_pkg::LENGTH_BITS-1:0]   o_token_length,
    output logic [ael_pkg::POSITION_BITS-1:0] o_token_line,
    output logic [ael_pkg::POSITION_BITS-1:0] o_token_column,
    output logic                              o_value_overflow,
    output logic                              o_last_of_run
);

    localparam int VB = ael_pkg::VALUE_BITS;
    localparam int PB = ael_pkg::POSITION_BITS;
    localparam int LB = ael_pkg::LENGTH_BITS;
    localparam logic [PB-1:0] POS_MAX = '1;
    localparam logic [LB-1:0] LEN_MAX = '1;

    // lexer state
    logic [PB-1:0] r_line, n_line;
    logic [PB-1:0] r_col, n_col;
    logic          r_seen, n_seen;
    logic          r_pend, n_pend;
    logic [VB-1:0] r_num, n_num;
    logic [LB-1:0] r_digits, n_digits;
    logic [PB-1:0] r_sline, n_sline;
    logic [PB-1:0] r_scol, n_scol;
    logic          r_wrap, n_wrap;

    // output queue, slot 0 is the head
    ael_pkg::t_token r_slot [3];
    ael_pkg::t_token n_slot [3];
    logic [1:0]      r_cnt, n_cnt;

    logic            pop, take;
    logic [1:0]      cnt_mid;
    logic [1:0]      tok_cnt;
    ael_pkg::t_token tok0, tok1, tok_int, tok_own;

    logic            is_digit, is_blank;
    logic [3:0]      digit;
    logic [VB+3:0]   prod;
    ael_pkg::t_kind  own_kind;

    assign pop        = (r_cnt != 2'd0) && i_out_ready;
    assign cnt_mid    = r_cnt - {1'b0, pop};
    assign o_in_ready = (cnt_mid <= 2'd1);
    assign take       = i_in_valid && o_in_ready;

    assign is_digit = (i_source_byte >= ael_pkg::CH_ZERO) && (i_source_byte <= ael_pkg::CH_NINE);
    assign is_blank = (i_source_byte == ael_pkg::CH_SPACE) || (i_source_byte == ael_pkg::CH_TAB)
                   || (i_source_byte == ael_pkg::CH_NL) || (i_source_byte == ael_pkg::CH_VT)
                   || (i_source_byte == ael_pkg::CH_FF) || (i_source_byte == ael_pkg::CH_CR);
    assign digit    = 4'(i_source_byte - ael_pkg::CH_ZERO);
    // value * 10 + digit as shift-add; any bit above VB means wrap
    assign prod     = ({4'd0, r_num} << 3) + ({4'd0, r_num} << 1) + (VB + 4)'(digit);

    always_comb begin
        priority if (i_source_byte == ael_pkg::CH_PLUS)  own_kind = ael_pkg::KIND_PLUS;
        else if (i_source_byte == ael_pkg::CH_MINUS)     own_kind = ael_pkg::KIND_MINUS;
        else if (i_source_byte == ael_pkg::CH_STAR)      own_kind = ael_pkg::KIND_STAR;
        else if (i_source_byte == ael_pkg::CH_SLASH)     own_kind = ael_pkg::KIND_SLASH;
        else                                             own_kind = ael_pkg::KIND_BAD;
    end

    // position and number update, token build
    always_comb begin
        n_seen   = r_seen;
        n_line   = r_line;
        n_col    = r_col;
        n_pend   = r_pend;
        n_num    = r_num;
        n_digits = r_digits;
        n_sline  = r_sline;
        n_scol   = r_scol;
        n_wrap   = r_wrap;
        tok_cnt  = 2'd0;
        tok0     = 'x;
        tok1     = 'x;

        // token for the number held before this byte
        tok_int.kind     = ael_pkg::KIND_INT;
        tok_int.value    = r_num;
        tok_int.length   = r_digits;
        tok_int.line     = r_sline;
        tok_int.column   = r_scol;
        tok_int.overflow = r_wrap;
        tok_int.last     = 1'b0;

        if (!r_seen) begin
            n_seen = 1'b1;
            n_line = PB'(1);
            n_col  = PB'(1);
        end else if (i_source_byte == ael_pkg::CH_NL) begin
            if (r_line < POS_MAX) n_line = r_line + PB'(1);
            n_col = '0;
        end else begin
            if (r_col < POS_MAX) n_col = r_col + PB'(1);
        end

        tok_own.kind     = own_kind;
        tok_own.value    = (own_kind == ael_pkg::KIND_BAD) ? VB'(i_source_byte) : '0;
        tok_own.length   = LB'(1);
        tok_own.line     = n_line;
        tok_own.column   = n_col;
        tok_own.overflow = 1'b0;
        tok_own.last     = 1'b0;

        if (is_digit) begin
            if (!r_pend) begin
                n_pend   = 1'b1;
                n_num    = VB'(digit);
                n_digits = LB'(1);
                n_sline  = n_line;
                n_scol   = n_col;
                n_wrap   = 1'b0;
            end else begin
                if (prod[VB+3:VB] != 4'd0) n_wrap = 1'b1;
                n_num = prod[VB-1:0];
                if (r_digits < LEN_MAX) n_digits = r_digits + LB'(1);
            end
            if (i_final_byte) begin
                // flush the number including this digit
                tok0.kind     = ael_pkg::KIND_INT;
                tok0.value    = n_num;
                tok0.length   = n_digits;
                tok0.line     = n_sline;
                tok0.column   = n_scol;
                tok0.overflow = n_wrap;
                tok0.last     = 1'b1;
                tok_cnt       = 2'd1;
            end
        end else begin
            n_pend = 1'b0;
            if (r_pend && !is_blank) begin
                tok0      = tok_int;
                tok1      = tok_own;
                tok1.last = 1'b1;
                tok_cnt   = 2'd2;
            end else if (r_pend) begin
                tok0      = tok_int;
                tok0.last = 1'b1;
                tok_cnt   = 2'd1;
            end else if (!is_blank) begin
                tok0      = tok_own;
                tok0.last = 1'b1;
                tok_cnt   = 2'd1;
            end
        end

        if (i_final_byte) begin
            n_seen = 1'b0;
            n_pend = 1'b0;
            n_line = PB'(1);
            n_col  = '0;
        end
    end

    // queue: shift on pop, then append new tokens behind what is left
    always_comb begin
        n_slot[0] = pop ? r_slot[1] : r_slot[0];
        n_slot[1] = pop ? r_slot[2] : r_slot[1];
        n_slot[2] = r_slot[2];
        for (int k = 0; k < 3; k++) begin
            if (take && (tok_cnt != 2'd0) && (cnt_mid == 2'(k))) n_slot[k] = tok0;
            if (take && (tok_cnt == 2'd2) && ((cnt_mid + 2'd1) == 2'(k))) n_slot[k] = tok1;
        end
        n_cnt = take ? (cnt_mid + tok_cnt) : cnt_mid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 2'd0;
            r_seen <= 1'b0;
            r_pend <= 1'b0;
            r_line <= PB'(1);
            r_col  <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (take) begin
                r_seen <= n_seen;
                r_pend <= n_pend;
                r_line <= n_line;
                r_col  <= n_col;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) r_slot[k] <= n_slot[k];
        if (take) begin
            r_num    <= n_num;
            r_digits <= n_digits;
            r_sline  <= n_sline;
            r_scol   <= n_scol;
            r_wrap   <= n_wrap;
        end
    end

    assign o_out_valid      = (r_cnt != 2'd0);
    assign o_token_kind     = r_slot[0].kind;
    assign o_token_value    = r_slot[0].value;
    assign o_token_length   = r_slot[0].length;
    assign o_token_line     = r_slot[0].line;
    assign o_token_column   = r_slot[0].column;
    assign o_value_overflow = r_slot[0].overflow;
    assign o_last_of_run    = r_slot[0].last;

endmodule

/* dv/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VB = ael_pkg::VALUE_BITS;
    localparam int PB = ael_pkg::POSITION_BITS;
    localparam int LB = ael_pkg::LENGTH_BITS;

    typedef logic [7:0] t_byte_q[$];

    // Cycles with neither channel moving an item before the run is declared hung.
    localparam int QUIET_LIMIT = 2000;

    // ------------------------------------------------------------------
    // Token tracker: a cycle-free model of the lexer plus the queue of
    // tokens it expects to see, in order.
    // ------------------------------------------------------------------
    class t_token_tracker;
        ael_pkg::t_token expected_tokens[$];
        int              errors;
        logic [PB-1:0]   cur_line;
        logic [PB-1:0]   cur_col;
        bit              started;
        bit              num_open;
        bit              num_wrapped;
        logic [VB-1:0]   num_value;
        logic [LB-1:0]   num_len;
        logic [PB-1:0]   num_line;
        logic [PB-1:0]   num_col;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            cur_line    = PB'(1);
            cur_col     = '0;
            started     = 1'b0;
            num_open    = 1'b0;
            num_wrapped = 1'b0;
            num_value   = '0;
            num_len     = '0;
            num_line    = '0;
            num_col     = '0;
        endfunction

        function int pending();
            return expected_tokens.size();
        endfunction

        function ael_pkg::t_token make_token(ael_pkg::t_kind kind, logic [VB-1:0] value,
                                             logic [LB-1:0] len, logic [PB-1:0] line,
                                             logic [PB-1:0] column, logic ovf);
            ael_pkg::t_token t;
            t.kind     = kind;
            t.value    = value;
            t.length   = len;
            t.line     = line;
            t.column   = column;
            t.overflow = ovf;
            t.last     = 1'b0;
            return t;
        endfunction

        // One accepted source item: update position and number state,
        // queue the zero, one or two tokens it produces.
        function void note_source_byte(logic [7:0] ch, logic fin);
            ael_pkg::t_token toks[$];
            logic [VB+3:0]   grown;
            logic [3:0]      dig;
            ael_pkg::t_kind  kind;
            logic [VB-1:0]   bad_value;

            if (!started) begin
                started  = 1'b1;
                cur_line = PB'(1);
                cur_col  = PB'(1);
            end else if (ch == ael_pkg::CH_NL) begin
                if (cur_line != '1) cur_line++;
                cur_col = '0;
            end else if (cur_col != '1) begin
                cur_col++;
            end

            if (ch >= ael_pkg::CH_ZERO && ch <= ael_pkg::CH_NINE) begin
                dig = 4'(ch - ael_pkg::CH_ZERO);
                if (!num_open) begin
                    num_open    = 1'b1;
                    num_value   = VB'(dig);
                    num_len     = LB'(1);
                    num_line    = cur_line;
                    num_col     = cur_col;
                    num_wrapped = 1'b0;
                end else begin
                    grown = {4'b0, num_value} * (VB + 4)'(10) + (VB + 4)'(dig);
                    if (grown[VB+3:VB] != 4'd0) num_wrapped = 1'b1;
                    num_value = grown[VB-1:0];
                    if (num_len != '1) num_len++;
                end
            end else begin
                if (num_open) begin
                    toks.push_back(make_token(ael_pkg::KIND_INT, num_value, num_len,
                                              num_line, num_col, num_wrapped));
                    num_open = 1'b0;
                end
                if (!(ch == ael_pkg::CH_SPACE || ch == ael_pkg::CH_TAB ||
                      ch == ael_pkg::CH_NL || ch == ael_pkg::CH_VT ||
                      ch == ael_pkg::CH_FF || ch == ael_pkg::CH_CR)) begin
                    bad_value = '0;
                    case (ch)
                        ael_pkg::CH_PLUS:  kind = ael_pkg::KIND_PLUS;
                        ael_pkg::CH_MINUS: kind = ael_pkg::KIND_MINUS;
                        ael_pkg::CH_STAR:  kind = ael_pkg::KIND_STAR;
                        ael_pkg::CH_SLASH: kind = ael_pkg::KIND_SLASH;
                        default: begin
                            kind      = ael_pkg::KIND_BAD;
                            bad_value = VB'(ch);
                        end
                    endcase
                    toks.push_back(make_token(kind, bad_value, LB'(1), cur_line, cur_col,
                                              1'b0));
                end
            end

            // final byte flushes a number still open
            if (fin && num_open) begin
                toks.push_back(make_token(ael_pkg::KIND_INT, num_value, num_len,
                                          num_line, num_col, num_wrapped));
                num_open = 1'b0;
            end

            if (toks.size() > 0) toks[toks.size()-1].last = 1'b1;
            foreach (toks[i]) expected_tokens.push_back(toks[i]);
            if (fin) restart();
        endfunction

        function string describe(ael_pkg::t_token t);
            return $sformatf("kind=%0d value=%0h len=%0d line=%0d col=%0d ovf=%0b last=%0b",
                             t.kind, t.value, t.length, t.line, t.column,
                             t.overflow, t.last);
        endfunction

        function void check_token(ael_pkg::t_token got);
            ael_pkg::t_token want;
            if (expected_tokens.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected token: %s", describe(got));
                return;
            end
            want = expected_tokens.pop_front();
            if (got.kind !== want.kind || got.value !== want.value ||
                got.length !== want.length || got.line !== want.line ||
                got.column !== want.column || got.overflow !== want.overflow ||
                got.last !== want.last) begin
                errors++;
                if (errors <= 10) begin
                    $display("token mismatch");
                    $display("  expected %s", describe(want));
                    $display("  actual   %s", describe(got));
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT hookup; every input has a known value from time zero.
    // ------------------------------------------------------------------
    logic          i_clk         = 1'b0;
    logic          i_rst_n       = 1'b0;
    logic          i_in_valid    = 1'b0;
    logic [7:0]    i_source_byte = 8'h00;
    logic          i_final_byte  = 1'b0;
    logic          i_out_ready   = 1'b0;
    logic          o_in_ready;
    logic          o_out_valid;
    logic [2:0]    o_token_kind;
    logic [VB-1:0] o_token_value;
    logic [LB-1:0] o_token_length;
    logic [PB-1:0] o_token_line;
    logic [PB-1:0] o_token_column;
    logic          o_value_overflow;
    logic          o_last_of_run;

    arith_expression_lexer_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_source_byte    (i_source_byte),
        .i_final_byte     (i_final_byte),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_token_kind     (o_token_kind),
        .o_token_value    (o_token_value),
        .o_token_length   (o_token_length),
        .o_token_line     (o_token_line),
        .o_token_column   (o_token_column),
        .o_value_overflow (o_value_overflow),
        .o_last_of_run    (o_last_of_run)
    );

    t_token_tracker board = new();

    // idle percentages per cycle; changed between phases
    int              sender_idle_pct = 0;
    int              sink_stall_pct  = 0;
    int              bytes_sent      = 0;
    int              quiet_cycles    = 0;
    ael_pkg::t_token seen_token;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Output side: take tokens, check them, randomize ready, and watch
    // for a hang. Everything is sampled at the edge, before this edge's
    // nonblocking updates land.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                seen_token.kind     = ael_pkg::t_kind'(o_token_kind);
                seen_token.value    = o_token_value;
                seen_token.length   = o_token_length;
                seen_token.line     = o_token_line;
                seen_token.column   = o_token_column;
                seen_token.overflow = o_value_overflow;
                seen_token.last     = o_last_of_run;
                board.check_token(seen_token);
            end
            if ((o_out_valid && i_out_ready) || (i_in_valid && o_in_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
                $display("arith_expression_lexer_top test failed");
                $finish;
            end
        end
        i_out_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // One source item: optional idle cycles, then hold valid until taken.
    task automatic send_byte(input logic [7:0] ch, input logic fin);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_source_byte <= ch;
        i_final_byte  <= fin;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        board.note_source_byte(ch, fin);
        bytes_sent++;
    endtask

    // A run of bytes; the last one closes the source when asked.
    task automatic send_text(input t_byte_q text, input bit close);
        foreach (text[i]) send_byte(text[i], close && (i == text.size() - 1));
    endtask

    // Sender holds off until every queued token has come out.
    task automatic drain_tokens();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (board.pending() != 0);
    endtask

    // Mostly expression-shaped text: numbers, operators, blanks, plus
    // some arbitrary bytes. Long numbers now and then to hit wraparound.
    function automatic void build_source(output t_byte_q text);
        int pick;
        int ndig;
        text = {};
        repeat ($urandom_range(1, 12)) begin
            pick = $urandom_range(99);
            if (pick < 35) begin
                ndig = ($urandom_range(7) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 4);
                repeat (ndig) text.push_back(8'(ael_pkg::CH_ZERO + $urandom_range(9)));
            end else if (pick < 65) begin
                case ($urandom_range(3))
                    0:       text.push_back(ael_pkg::CH_PLUS);
                    1:       text.push_back(ael_pkg::CH_MINUS);
                    2:       text.push_back(ael_pkg::CH_STAR);
                    default: text.push_back(ael_pkg::CH_SLASH);
                endcase
            end else if (pick < 85) begin
                case ($urandom_range(5))
                    0:       text.push_back(ael_pkg::CH_SPACE);
                    1:       text.push_back(ael_pkg::CH_TAB);
                    2:       text.push_back(ael_pkg::CH_NL);
                    3:       text.push_back(ael_pkg::CH_VT);
                    4:       text.push_back(ael_pkg::CH_FF);
                    default: text.push_back(ael_pkg::CH_CR);
                endcase
            end else begin
                text.push_back(8'($urandom_range(255)));
            end
        end
    endfunction

    task automatic random_sources(input int upto);
        t_byte_q text;
        while (bytes_sent < upto) begin
            build_source(text);
            // a few sources are left open and run on into the next one
            send_text(text, $urandom_range(9) != 0);
        end
    endtask

    initial begin
        t_byte_q text;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // phase one: sender idles a little, receiver a lot
        sender_idle_pct = 13;
        sink_stall_pct  = 70;

        // directed: a one-byte source that is itself the final byte
        send_byte(8'h00, 1'b1);
        // number closed by an operator on the final byte: two tokens
        text = {8'h37, ael_pkg::CH_PLUS};
        send_text(text, 1'b1);
        // leading blank, a ten-digit number that wraps (4294967296),
        // every operator, every blank kind, a high byte, then a number
        // flushed by the final byte
        text = {ael_pkg::CH_SPACE, 8'h34, 8'h32, 8'h39, 8'h34, 8'h39, 8'h36, 8'h37,
                8'h32, 8'h39, 8'h36, ael_pkg::CH_PLUS, ael_pkg::CH_MINUS,
                ael_pkg::CH_STAR, ael_pkg::CH_SLASH, ael_pkg::CH_TAB, ael_pkg::CH_VT,
                ael_pkg::CH_FF, ael_pkg::CH_CR, ael_pkg::CH_NL, 8'hFF,
                ael_pkg::CH_ZERO, ael_pkg::CH_NINE};
        send_text(text, 1'b1);

        random_sources(250);
        drain_tokens();

        // phase two: roles swapped
        sender_idle_pct = 70;
        sink_stall_pct  = 13;
        random_sources(500);
        drain_tokens();

        // phase three: full rate both ways
        sender_idle_pct = 0;
        sink_stall_pct  = 0;
        random_sources(650);

        // saturation: digit count past its max in one long number,
        // closed by an operator on the final byte
        text = {};
        repeat (300) text.push_back(8'(ael_pkg::CH_ZERO + $urandom_range(9)));
        text.push_back(ael_pkg::CH_PLUS);
        send_text(text, 1'b1);
        drain_tokens();

        // let any late token show up
        repeat (8) @(posedge i_clk);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("arith_expression_lexer_top test passed");
        end else begin
            $display("arith_expression_lexer_top test failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
sv/ael_pkg.sv
sv/arith_expression_lexer_top.sv
dv/testbench.sv
